>>> sv/sst_pkg.sv
// Shared types and constants for the sum segment tree unit.
package sst_pkg;

  // Default number of leaves (power of two)
  localparam int LEAVES_DEF = 1024;

  // Fixed field widths
  localparam int LO_W  = 10;
  localparam int HI_W  = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_POINT_ADD = 2'd0,
    MODE_RANGE_ADD = 2'd1,
    MODE_RANGE_SUM = 2'd2,
    MODE_PREFIX    = 2'd3
  } mode_t;

endpackage

>>> sv/sum_segment_tree_unit.sv
// Sum segment tree unit: point add, range add, range sum and prefix sum over one node memory.
//
// The tree of 2*LEAVES 64-bit node sums lives in one synchronous memory (two read
// ports, one write port, registered reads). After reset the unit sweeps the memory
// to zero, one node per cycle, with busy high. A transfer takes place at a clock
// edge with start high and busy low. A point add walks from the leaf to the root,
// reading a node while the node below is written back, with busy high; a range add
// adds the value at leaf lo and subtracts it at leaf hi, one such walk per end, back
// to back. An add aimed past the last leaf, or a range add end past it, changes nothing.
// Queries walk both range ends upward one level per cycle, reading up to two nodes,
// with busy high. A query result appears on out_sum with out_valid high for exactly
// one cycle; there is no way to hold it off, and the next transfer may be taken while
// it is shown.
module sum_segment_tree_unit #(
  parameter int LEAVES = sst_pkg::LEAVES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_mode,
  input  logic [sst_pkg::LO_W-1:0]       in_lo_index,
  input  logic [sst_pkg::HI_W-1:0]       in_hi_index,
  input  logic signed [sst_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  output logic signed [sst_pkg::SUM_W-1:0] out_sum
);

  localparam int IW    = $clog2(LEAVES);          // leaf index width
  localparam int AW    = IW + 1;                  // node address width
  localparam int NW    = IW + 2;                  // walk index width, holds 2*LEAVES
  localparam int DEPTH = 2 * LEAVES;
  localparam int XW    = (sst_pkg::HI_W + 1 > NW) ? sst_pkg::HI_W + 1 : NW;
  localparam int SW    = sst_pkg::SUM_W;

  localparam logic [XW-1:0] LEAVES_X = XW'(LEAVES);
  localparam logic [AW-1:0] ROOT     = AW'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_ADD_LAST,
    ST_SUM,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic [AW-1:0]     node2_r, node2_nxt;
  logic              second_r, second_nxt;
  logic [SW-1:0]     amt_r, amt_nxt;
  logic              wb_vld_r, wb_vld_nxt;
  logic [AW-1:0]     wb_addr_r, wb_addr_nxt;
  logic [NW-1:0]     a_r, a_nxt;
  logic [NW-1:0]     b_r, b_nxt;
  logic              va_r, va_nxt;
  logic              vb_r, vb_nxt;
  logic [SW-1:0]     acc_a_r, acc_a_nxt;
  logic [SW-1:0]     acc_b_r, acc_b_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     out_sum_r, out_sum_nxt;

  // Node memory and its ports
  logic [SW-1:0]     mem [DEPTH];
  logic [SW-1:0]     qa, qb;
  logic [AW-1:0]     ra, rb, wa;
  logic [SW-1:0]     wd;
  logic              we;

  // Decoded input
  sst_pkg::mode_t    mode;
  logic [XW-1:0]     lo_x, hi_x, first_x, last_x;
  logic [SW-1:0]     amt_in;
  logic              lo_ok, hi_ok, take;
  logic [NW-1:0]     b_dec;

  assign busy      = (state_r != ST_IDLE);
  assign take      = start && !busy;
  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

  assign mode   = sst_pkg::mode_t'(in_mode);
  assign lo_x   = XW'(in_lo_index);
  assign hi_x   = XW'(in_hi_index);
  assign amt_in = SW'(in_value);
  assign lo_ok  = (lo_x < LEAVES_X);
  assign hi_ok  = (hi_x < LEAVES_X);
  assign b_dec  = b_r - NW'(1);

  // Query bounds: saturate the end, prefix covers leaves 0 through lo
  always_comb begin
    if (mode == sst_pkg::MODE_PREFIX) begin
      first_x = '0;
      last_x  = lo_ok ? lo_x + XW'(1) : LEAVES_X;
    end else begin
      first_x = lo_x;
      last_x  = hi_ok ? hi_x : LEAVES_X;
    end
  end

  // Memory port selection
  assign ra = (state_r == ST_ADD) ? node_r : a_r[AW-1:0];
  assign rb = b_dec[AW-1:0];
  assign we = (state_r == ST_CLEAR) || wb_vld_r;
  assign wa = (state_r == ST_CLEAR) ? clr_r : wb_addr_r;
  assign wd = (state_r == ST_CLEAR) ? '0 : qa + amt_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    node2_nxt     = node2_r;
    second_nxt    = second_r;
    amt_nxt       = amt_r;
    wb_vld_nxt    = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    va_nxt        = 1'b0;
    vb_nxt        = 1'b0;
    acc_a_nxt     = va_r ? acc_a_r + qa : acc_a_r;
    acc_b_nxt     = vb_r ? acc_b_r + qb : acc_b_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          unique case (mode)
            sst_pkg::MODE_POINT_ADD: begin
              node_nxt   = {1'b1, lo_x[IW-1:0]};
              amt_nxt    = amt_in;
              second_nxt = 1'b0;
              if (lo_ok) begin
                state_nxt = ST_ADD;
              end
            end
            sst_pkg::MODE_RANGE_ADD: begin
              node2_nxt = {1'b1, hi_x[IW-1:0]};
              if (lo_ok) begin
                node_nxt   = {1'b1, lo_x[IW-1:0]};
                amt_nxt    = amt_in;
                second_nxt = hi_ok;
                state_nxt  = ST_ADD;
              end else if (hi_ok) begin
                node_nxt   = {1'b1, hi_x[IW-1:0]};
                amt_nxt    = SW'(0) - amt_in;
                second_nxt = 1'b0;
                state_nxt  = ST_ADD;
              end
            end
            sst_pkg::MODE_RANGE_SUM,
            sst_pkg::MODE_PREFIX: begin
              a_nxt     = NW'(first_x + LEAVES_X);
              b_nxt     = NW'(last_x + LEAVES_X);
              acc_a_nxt = '0;
              acc_b_nxt = '0;
              state_nxt = ST_SUM;
            end
          endcase
        end
      end
      // Read one node per level, write back the level below
      ST_ADD: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = node_r;
        node_nxt    = node_r >> 1;
        if (node_r == ROOT) begin
          state_nxt = ST_ADD_LAST;
        end
      end
      // Root write lands here; chain the negated add if pending
      ST_ADD_LAST: begin
        if (second_r) begin
          second_nxt = 1'b0;
          node_nxt   = node2_r;
          amt_nxt    = SW'(0) - amt_r;
          state_nxt  = ST_ADD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      // Both range ends climb one level per cycle
      ST_SUM: begin
        if (a_r < b_r) begin
          va_nxt = a_r[0];
          vb_nxt = b_r[0];
          a_nxt  = (a_r + NW'(a_r[0])) >> 1;
          b_nxt  = b_r >> 1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = acc_a_r + acc_b_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      second_r    <= 1'b0;
      wb_vld_r    <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      second_r    <= second_nxt;
      wb_vld_r    <= wb_vld_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r    <= node_nxt;
    node2_r   <= node2_nxt;
    amt_r     <= amt_nxt;
    wb_addr_r <= wb_addr_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_a_r   <= acc_a_nxt;
    acc_b_r   <= acc_b_nxt;
    out_sum_r <= out_sum_nxt;
  end

  // A result strobe only follows the final query state
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FIN))
    else $error("result strobe without finished query");

  // Outside the clearing sweep the unused node 0 is never written
  a_no_node0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r != ST_CLEAR) |-> (wa != '0))
    else $error("write to unused node 0");

  // The upward walk never reaches past the root
  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> (node_r != '0))
    else $error("add walk past root");

  // An add transfer never yields a result
  a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_mode == sst_pkg::MODE_POINT_ADD || in_mode == sst_pkg::MODE_RANGE_ADD))
    |=> !out_valid_r)
    else $error("result after add");

endmodule

>>> verif/sum_segment_tree_unit_test.sv
// Self-checking testbench for the sum segment tree unit: random and directed updates and queries.
module sum_segment_tree_unit_test;

  localparam int LEAVES        = sst_pkg::LEAVES_DEF;
  localparam int STALL_LIMIT   = 10000;  // outlasts the clearing sweep; gaps are capped
  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_GAP       = 60;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 410;

  // Shadow of the node memory plus the queue of sums still owed by the block
  class tree_sum_checker;
    bit [sst_pkg::SUM_W-1:0] node_sum [2*LEAVES];
    bit [sst_pkg::SUM_W-1:0] pending_sums [$];
    int op_count [4];
    int checked;
    int mismatches;

    // Add to one leaf, then rebuild its ancestors; leaves past the end are dropped
    function void leaf_add(int unsigned leaf, bit [sst_pkg::SUM_W-1:0] amount);
      int unsigned n;
      if (leaf >= LEAVES) return;
      n = leaf + LEAVES;
      node_sum[n] += amount;
      for (n = n >> 1; n != 0; n = n >> 1)
        node_sum[n] = node_sum[2*n] + node_sum[2*n+1];
    endfunction

    // Sum of leaves in [first, last), walking both ends upward
    function bit [sst_pkg::SUM_W-1:0] span_total(int unsigned first, int unsigned last);
      bit [sst_pkg::SUM_W-1:0] acc;
      int unsigned a;
      int unsigned b;
      acc = '0;
      if (first >= last) return acc;
      a = first + LEAVES;
      b = last + LEAVES;
      while (a < b) begin
        if ((a & 1) != 0) begin
          acc += node_sum[a];
          a++;
        end
        if ((b & 1) != 0) begin
          b--;
          acc += node_sum[b];
        end
        a = a >> 1;
        b = b >> 1;
      end
      return acc;
    endfunction

    // Apply one accepted transfer; queries queue the sum they must return
    function void note_transfer(sst_pkg::mode_t m, bit [sst_pkg::LO_W-1:0] lo,
                                bit [sst_pkg::HI_W-1:0] hi, bit [sst_pkg::VAL_W-1:0] v);
      bit [sst_pkg::SUM_W-1:0] amount;
      int unsigned end_leaf;
      int unsigned last_leaf;
      amount = {{(sst_pkg::SUM_W-sst_pkg::VAL_W){v[sst_pkg::VAL_W-1]}}, v};
      op_count[int'(m)]++;
      case (m)
        sst_pkg::MODE_POINT_ADD: begin
          leaf_add(32'(lo), amount);
        end
        sst_pkg::MODE_RANGE_ADD: begin
          leaf_add(32'(lo), amount);
          if (32'(hi) != LEAVES) leaf_add(32'(hi), {sst_pkg::SUM_W{1'b0}} - amount);
        end
        sst_pkg::MODE_RANGE_SUM: begin
          end_leaf = (32'(hi) > LEAVES) ? LEAVES : 32'(hi);
          pending_sums = {pending_sums, span_total(32'(lo), end_leaf)};
        end
        sst_pkg::MODE_PREFIX: begin
          last_leaf = (32'(lo) > LEAVES - 1) ? LEAVES - 1 : 32'(lo);
          pending_sums = {pending_sums, span_total(0, last_leaf + 1)};
        end
      endcase
    endfunction

    // Compare one strobed sum against the oldest owed sum
    function void check_result(logic [sst_pkg::SUM_W-1:0] got);
      bit [sst_pkg::SUM_W-1:0] want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: sum %0d with nothing owed", $signed(got));
        return;
      end
      want = pending_sums.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("sum mismatch on result %0d: expected %0d (%h), got %0d (%h)",
                   checked, $signed(want), want, $signed(got), got);
      end
    endfunction

    function int owed();
      return pending_sums.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [1:0]                       in_mode;
  logic [sst_pkg::LO_W-1:0]         in_lo_index;
  logic [sst_pkg::HI_W-1:0]         in_hi_index;
  logic signed [sst_pkg::VAL_W-1:0] in_value;
  logic                             out_valid;
  logic signed [sst_pkg::SUM_W-1:0] out_sum;

  tree_sum_checker sums;
  int idle_pct;
  int stall_cycles;

  sum_segment_tree_unit #(.LEAVES(LEAVES)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_lo_index (in_lo_index),
    .in_hi_index (in_hi_index),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_sum     (out_sum)
  );

  always #2 clk = ~clk;

  // Monitor: results first, so a sum shown in the cycle of a new transfer pairs correctly
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (out_valid) sums.check_result(out_sum);
      if (start && !busy)
        sums.note_transfer(sst_pkg::mode_t'(in_mode), in_lo_index, in_hi_index, in_value);
      if (out_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d sums owed",
                 stall_cycles, sums.owed());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Sender idle length, geometric with the current idle percentage
  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // Present one command and hold it until the block takes it
  task automatic send_op(input sst_pkg::mode_t m, input bit [sst_pkg::LO_W-1:0] lo,
                         input bit [sst_pkg::HI_W-1:0] hi,
                         input bit [sst_pkg::VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= m;
    in_lo_index <= lo;
    in_hi_index <= hi;
    in_value    <= v;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every owed sum has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sums.owed() != 0);
  endtask

  function automatic bit [sst_pkg::VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(7);
    case (sel)
      0:       return (($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
      1, 2, 3: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  // One random command: mostly sensible ranges, some ends past the last leaf
  task automatic send_random();
    sst_pkg::mode_t m;
    bit [sst_pkg::LO_W-1:0] lo;
    bit [sst_pkg::HI_W-1:0] hi;
    int sel;
    m = sst_pkg::mode_t'($urandom_range(3));
    sel = $urandom_range(9);
    lo = (sel == 0) ? '0 : (sel == 1) ? {sst_pkg::LO_W{1'b1}} : sst_pkg::LO_W'($urandom());
    sel = $urandom_range(9);
    if (m == sst_pkg::MODE_POINT_ADD || m == sst_pkg::MODE_PREFIX || sel == 0)
      hi = sst_pkg::HI_W'($urandom());
    else if (sel == 1)
      hi = sst_pkg::HI_W'(LEAVES);
    else
      hi = sst_pkg::HI_W'(32'(lo) + $urandom_range(LEAVES - 32'(lo)));
    send_op(m, lo, hi, pick_value());
  endtask

  initial begin
    sums = new();
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_mode     <= sst_pkg::MODE_POINT_ADD;
    in_lo_index <= '0;
    in_hi_index <= '0;
    in_value    <= '0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: cleared tree, extreme values, saturation, empty and reversed ranges
    send_op(sst_pkg::MODE_PREFIX,    10'd1023, 11'd0,    32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd0,    11'd1024, 32'd0);
    send_op(sst_pkg::MODE_POINT_ADD, 10'd0,    11'd0,    32'h7FFF_FFFF);
    send_op(sst_pkg::MODE_POINT_ADD, 10'd1023, 11'd2047, 32'h8000_0000);
    send_op(sst_pkg::MODE_POINT_ADD, 10'd512,  11'd0,    32'hFFFF_FFFF);
    send_op(sst_pkg::MODE_POINT_ADD, 10'd3,    11'd0,    32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd0,    11'd1024, 32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd0,    11'd2047, 32'hFFFF_FFFF);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd1023, 11'd1024, 32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd5,    11'd5,    32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd900,  11'd100,  32'd0);
    send_op(sst_pkg::MODE_PREFIX,    10'd0,    11'd0,    32'd0);
    send_op(sst_pkg::MODE_PREFIX,    10'd1023, 11'd0,    32'd0);
    send_op(sst_pkg::MODE_RANGE_ADD, 10'd100,  11'd200,  -32'sd5);
    send_op(sst_pkg::MODE_RANGE_ADD, 10'd300,  11'd1024, 32'd1234);
    send_op(sst_pkg::MODE_RANGE_ADD, 10'd400,  11'd1500, 32'd99);
    send_op(sst_pkg::MODE_RANGE_ADD, 10'd700,  11'd300,  32'd42);
    send_op(sst_pkg::MODE_RANGE_ADD, 10'd0,    11'd0,    32'h1234_5678);
    send_op(sst_pkg::MODE_PREFIX,    10'd150,  11'd0,    32'd0);
    send_op(sst_pkg::MODE_PREFIX,    10'd350,  11'd0,    32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd0,    11'd1024, 32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd250,  11'd1100, 32'd0);
    send_op(sst_pkg::MODE_PREFIX,    10'd700,  11'd0,    32'd0);
    send_op(sst_pkg::MODE_RANGE_SUM, 10'd300,  11'd700,  32'd0);
    drain();

    // Random phases: back to back, heavy sender idling, light sender idling
    repeat (PHASE_ITEMS) send_random();
    idle_pct = 64;
    repeat (PHASE_ITEMS / 2) send_random();
    drain();
    repeat (PHASE_ITEMS / 2) send_random();
    idle_pct = 11;
    repeat (PHASE_ITEMS) send_random();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sums.owed() != 0) $display("%0d sums never returned", sums.owed());
    $display("Ran %0d point adds, %0d range adds, %0d range sums, %0d prefix queries;",
             sums.op_count[0], sums.op_count[1], sums.op_count[2], sums.op_count[3]);
    $display("%0d sums compared, %0d mismatches", sums.checked, sums.mismatches);
    if (sums.mismatches == 0 && sums.owed() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
